@@ design/rcc_pkg.sv @@
// Shared types and constants for the rounded corner coverage block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rcc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd4;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    localparam logic [31:0] ROOT_TOP = 32'h4000_0000;
    localparam int ROOT_STAGES = 8;
    localparam int ROOT_STEPS = 2;

    localparam logic [8:0] COV_FULL = 9'd256;

    localparam int QDEPTH = 8;
    localparam int QAW = 3;
    localparam int CREDIT_W = 4;

    typedef struct packed {
        logic signed [11:0] left;
        logic signed [11:0] top;
        logic signed [11:0] width;
        logic signed [11:0] height;
    } t_cfg;

    typedef struct packed {
        logic [5:0] dx;
        logic [5:0] dy;
        logic [8:0] cov;
    } t_item;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] res;
    } t_root;

    function automatic t_root root_step(input t_root s, input logic [31:0] bitv);
        t_root       o;
        logic [31:0] trial;
        trial = s.res + bitv;
        if (s.rem >= trial) begin
            o.rem = s.rem - trial;
            o.res = (s.res >> 1) + bitv;
        end else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

endpackage

@@ design/rcc_isqrt.sv @@
// Pipelined integer square root, two digit steps per stage.
// Depends on rcc_pkg for the step function and stage counts.
`timescale 1ns / 1ps

module rcc_isqrt #(
    parameter int TW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_value,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [15:0]   o_root,
    output logic [TW-1:0] o_tag
);

    localparam int NS = rcc_pkg::ROOT_STAGES;

    rcc_pkg::t_root r_st  [NS];
    logic           r_vld [NS];
    logic [TW-1:0]  r_tag [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        rcc_pkg::t_root w_in;
        rcc_pkg::t_root n_st;
        logic           w_vld;
        logic [TW-1:0]  w_tag;

        if (k == 0) begin : g_first
            assign w_in.rem = i_value;
            assign w_in.res = '0;
            assign w_vld    = i_valid;
            assign w_tag    = i_tag;
        end else begin : g_next
            assign w_in  = r_st[k-1];
            assign w_vld = r_vld[k-1];
            assign w_tag = r_tag[k-1];
        end

        always_comb begin
            n_st = w_in;
            for (int j = 0; j < rcc_pkg::ROOT_STEPS; j++) begin
                n_st = rcc_pkg::root_step(n_st,
                    rcc_pkg::ROOT_TOP >> (2 * (rcc_pkg::ROOT_STEPS * k + j)));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[k]  <= n_st;
            r_tag[k] <= w_tag;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_st[NS-1].res[15:0];
    assign o_tag   = r_tag[NS-1];

endmodule

@@ design/rcc_front.sv @@
// Front part: configuration registers, radius clamp, offset classification,
// squared distance, square root and coverage. Depends on rcc_pkg and rcc_isqrt.
`timescale 1ns / 1ps

module rcc_front #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [5:0]                         i_offset_x,
    input  logic [5:0]                         i_offset_y,
    input  logic                               i_cfg_valid,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_pop,
    output logic                               o_push,
    output rcc_pkg::t_item                     o_push_item,
    output rcc_pkg::t_cfg                      o_cfg
);

    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int CMPW = (RW > 6) ? RW : 6;
    localparam int TW = 1 + RW + 12;

    logic signed [11:0] r_left, r_top, r_width, r_height;
    logic [5:0]         r_radius;

    logic                         w_accept;
    logic [rcc_pkg::CREDIT_W-1:0] r_credit, n_credit;

    logic          r_a_vld, r_a_nonempty;
    logic [RW-1:0] r_a_r;
    logic [5:0]    r_a_dx, r_a_dy;

    logic [11:0]   w_half_w, w_half_h, w_m1, w_m2, w_m3;

    logic          r_b_vld;
    logic [TW-1:0] r_b_tag;
    logic [12:0]   r_b_sum;

    logic            w_ok;
    logic [CMPW-1:0] w_cx_full, w_cy_full;
    logic [5:0]      w_cx, w_cy;
    logic [11:0]     w_sq_x, w_sq_y;

    logic          w_s_vld;
    logic [15:0]   w_s_root;
    logic [TW-1:0] w_s_tag;
    logic [RW-1:0] w_s_r;
    logic [17:0]   w_cov;
    logic          w_pos;

    logic           r_push, r_drop;
    rcc_pkg::t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_radius <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcc_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                rcc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                rcc_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                rcc_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                rcc_pkg::CFG_RADIUS: r_radius <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.left   = r_left;
    assign o_cfg.top    = r_top;
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

    // Each accepted offset holds one credit until it is dropped or leaves the queue.
    assign busy     = (r_credit == rcc_pkg::CREDIT_W'(rcc_pkg::QDEPTH));
    assign w_accept = start && !busy;
    assign n_credit = r_credit + rcc_pkg::CREDIT_W'(w_accept)
                    - rcc_pkg::CREDIT_W'(r_drop) - rcc_pkg::CREDIT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    assign w_half_w = 12'(r_width >>> 1);
    assign w_half_h = 12'(r_height >>> 1);

    always_comb begin
        w_m1 = ({6'b0, r_radius} < 12'(MAX_RADIUS)) ? {6'b0, r_radius} : 12'(MAX_RADIUS);
        w_m2 = (w_m1 < w_half_w) ? w_m1 : w_half_w;
        w_m3 = (w_m2 < w_half_h) ? w_m2 : w_half_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_nonempty <= !r_width[11] && (r_width != '0) && !r_height[11] && (r_height != '0);
        r_a_r        <= w_m3[RW-1:0];
        r_a_dx       <= i_offset_x;
        r_a_dy       <= i_offset_y;
    end

    always_comb begin
        w_ok = r_a_nonempty && (CMPW'(r_a_dx) < CMPW'(r_a_r))
            && (CMPW'(r_a_dy) < CMPW'(r_a_r));
        w_cx_full = CMPW'(r_a_r) - CMPW'(r_a_dx) - CMPW'(1);
        w_cy_full = CMPW'(r_a_r) - CMPW'(r_a_dy) - CMPW'(1);
        w_cx = w_cx_full[5:0];
        w_cy = w_cy_full[5:0];
        w_sq_x = 12'(w_cx) * 12'(w_cx);
        w_sq_y = 12'(w_cy) * 12'(w_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_tag <= {w_ok, r_a_r, r_a_dx, r_a_dy};
        r_b_sum <= 13'(w_sq_x) + 13'(w_sq_y);
    end

    rcc_isqrt #(
        .TW(TW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_b_vld),
        .i_value ({3'b0, r_b_sum, 16'b0}),
        .i_tag   (r_b_tag),
        .o_valid (w_s_vld),
        .o_root  (w_s_root),
        .o_tag   (w_s_tag)
    );

    assign w_s_r = w_s_tag[RW+11:12];
    assign w_cov = 18'(w_s_root) + 18'd256 - (18'(w_s_r) << 8);
    assign w_pos = !w_cov[17] && (w_cov != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push <= 1'b0;
            r_drop <= 1'b0;
        end else begin
            r_push <= w_s_vld && w_s_tag[TW-1] && w_pos;
            r_drop <= w_s_vld && !(w_s_tag[TW-1] && w_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        r_item.dx  <= w_s_tag[11:6];
        r_item.dy  <= w_s_tag[5:0];
        r_item.cov <= (w_cov[16:0] > 17'(rcc_pkg::COV_FULL)) ? rcc_pkg::COV_FULL : w_cov[8:0];
    end

    assign o_push      = r_push;
    assign o_push_item = r_item;

endmodule

@@ design/rcc_queue.sv @@
// Short queue of drawing offsets between the front and the back part.
// Depends on rcc_pkg for the item type and depth.
`timescale 1ns / 1ps

module rcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rcc_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_empty,
    output rcc_pkg::t_item o_item
);

    rcc_pkg::t_item        r_mem [rcc_pkg::QDEPTH];
    logic [rcc_pkg::QAW-1:0] r_wptr, r_rptr;
    logic [rcc_pkg::QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (rcc_pkg::QAW + 1)'(i_push) - (rcc_pkg::QAW + 1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

endmodule

@@ design/rcc_back.sv @@
// Back part: sends the four mirrored pixels of each queued offset, one a cycle.
// Depends on rcc_pkg for the item and configuration types.
`timescale 1ns / 1ps

module rcc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rcc_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    input  rcc_pkg::t_item     i_item,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [12:0] o_pixel_x,
    output logic signed [12:0] o_pixel_y,
    output logic [8:0]         o_coverage,
    output logic [1:0]         o_corner_index,
    output logic               o_last
);

    logic           r_active;
    logic [1:0]     r_idx;
    rcc_pkg::t_item r_item;
    logic [12:0]    w_xl, w_xr, w_yt, w_yb;

    assign o_pop = !i_empty && (!r_active || (r_idx == rcc_pkg::CORNER_BR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= rcc_pkg::CORNER_TL;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_idx    <= rcc_pkg::CORNER_TL;
        end else if (r_active) begin
            r_idx <= r_idx + 2'd1;
            if (r_idx == rcc_pkg::CORNER_BR) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        w_xl = {i_cfg.left[11], i_cfg.left} + {7'b0, r_item.dx};
        w_xr = {i_cfg.left[11], i_cfg.left} + {i_cfg.width[11], i_cfg.width}
             - 13'd1 - {7'b0, r_item.dx};
        w_yt = {i_cfg.top[11], i_cfg.top} + {7'b0, r_item.dy};
        w_yb = {i_cfg.top[11], i_cfg.top} + {i_cfg.height[11], i_cfg.height}
             - 13'd1 - {7'b0, r_item.dy};
    end

    assign o_valid        = r_active;
    assign o_pixel_x      = r_idx[0] ? w_xr : w_xl;
    assign o_pixel_y      = r_idx[1] ? w_yb : w_yt;
    assign o_coverage     = r_item.cov;
    assign o_corner_index = r_idx;
    assign o_last         = (r_idx == rcc_pkg::CORNER_BR);

endmodule

@@ design/rounded_corner_coverage.sv @@
// Top level of the rounded corner coverage block.
// Depends on rcc_pkg, rcc_front, rcc_queue and rcc_back.
`timescale 1ns / 1ps

// An offset is taken whenever start is high and busy is low, at most one per
// cycle. Eight offsets may be in flight or queued; busy is high while all eight
// credits are held. Each offset that draws occupies the result port for its four
// pixels on consecutive cycles, so the sustained rate of drawing offsets is set
// by the single result port; offsets that draw nothing leave no trace at the
// port. With the queue empty an offset passes the classification and sum
// registers, the eight-stage square root pipeline, which makes up most of the
// path, the push register, the queue and the pixel registers of the back part
// before its first pixel is on the ports. Results cannot be held off: each
// pixel is on the ports for one cycle with o_valid high, in the order top-left,
// top-right, bottom-left, bottom-right, with o_last on the fourth. Configuration
// writes are always ready and should only be made while no offsets are in flight.
module rounded_corner_coverage #(
    parameter int MAX_RADIUS = 63
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [5:0]                     i_offset_x,
    input  logic [5:0]                     i_offset_y,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output logic signed [12:0]             o_pixel_x,
    output logic signed [12:0]             o_pixel_y,
    output logic [8:0]                     o_coverage,
    output logic [1:0]                     o_corner_index,
    output logic                           o_last
);

    logic           w_push, w_pop, w_empty;
    rcc_pkg::t_item w_push_item, w_head;
    rcc_pkg::t_cfg  w_cfg;

    assign o_cfg_ready = 1'b1;

    rcc_front #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_offset_x  (i_offset_x),
        .i_offset_y  (i_offset_y),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (w_pop),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .o_cfg       (w_cfg)
    );

    rcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    rcc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_empty        (w_empty),
        .i_item         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_coverage     (o_coverage),
        .o_corner_index (o_corner_index),
        .o_last         (o_last)
    );

endmodule

@@ design/rcc_checker.sv @@
// Port-level checks on reset, configuration writes and the result bursts of the rounded corner coverage block.
// Depends on rcc_pkg; bound to rounded_corner_coverage at the end of this file.
`timescale 1ns / 1ps

module rcc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       o_valid,
    input logic [8:0] o_coverage,
    input logic [1:0] o_corner_index,
    input logic       o_last
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("result strobe or busy after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write not taken");

    a_last_marks_br: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_corner_index == rcc_pkg::CORNER_BR)))
        else $error("last does not match the bottom-right pixel");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid
            && (o_corner_index == $past(o_corner_index) + 2'd1)
            && $stable(o_coverage))
        else $error("pixel burst broken");

    a_coverage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coverage != 9'd0) && (o_coverage <= rcc_pkg::COV_FULL))
        else $error("coverage out of range");

endmodule

bind rounded_corner_coverage rcc_checker u_rcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready),
    .o_valid        (o_valid),
    .o_coverage     (o_coverage),
    .o_corner_index (o_corner_index),
    .o_last         (o_last)
);
